@@ rtl/assert_macros.svh @@
// Assertion helper macros shared by the detector RTL.
// Included by the top module for its concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define MBTD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define MBTD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/mbtd_pkg.sv @@
// Package for the modulated beam trip detector: widths, register indexes,
// reset values and the flag bundle carried from the decision step onwards.
// Depends on nothing.
package mbtd_pkg;

   // Field widths.
   localparam int ADC_W     = 10;
   localparam int TIME_W    = 32;
   localparam int CNT_W     = 16;
   localparam int HOLD_W    = 16;
   localparam int RET_W     = 4;
   localparam int GOOD_W    = 3;
   localparam int SPEED_W   = 26;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 26;
   localparam int STEP_W    = 5;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CHANGE_MARGIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MISS_LIMIT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_MS         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RETURN_COUNT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_NUMERATOR = 3'd4;

   // Register reset values.
   localparam logic [ADC_W-1:0]   MARGIN_RST     = 10'd10;
   localparam logic [CNT_W-1:0]   MISS_LIMIT_RST = 16'd20;
   localparam logic [HOLD_W-1:0]  HOLD_MS_RST    = 16'd200;
   localparam logic [RET_W-1:0]   RETURN_RST     = 4'd5;
   localparam logic [SPEED_W-1:0] NUMERATOR_RST  = 26'd28900000;

   // Counter limits.
   localparam logic [CNT_W-1:0]  MISS_MAX   = '1;
   localparam logic [RET_W-1:0]  BACK_MAX   = '1;
   localparam logic [GOOD_W-1:0] GOOD_LIMIT = 3'd3;

   // Last cycle of the bit-serial pass and of the divider.
   localparam logic [STEP_W-1:0] LAST_BIT_STEP = STEP_W'(TIME_W - 1);
   localparam logic [STEP_W-1:0] LAST_DIV_STEP = STEP_W'(SPEED_W - 1);

   // Decisions taken when a request is accepted, resolved when it finishes.
   typedef struct packed {
      logic trip;      // miss count passed the limit
      logic ev_start;  // trip newly declared
      logic ev_end;    // trip end confirmed, speed to be computed
   } step_flags_type;

endpackage

@@ rtl/modulated_beam_trip_detector.sv @@
// Top level of the modulated beam trip detector.
// Depends on mbtd_pkg and on assert_macros.svh for its checks.
//
// Usage
//   Requests arrive on req_* (valid/stall) and carry one ADC reading with its
//   microsecond and millisecond timestamps. Each request gives exactly one
//   response on rsp_*: laser level, LED level, trip flag, the three events
//   and the last computed speed.
//   The response is registered after the serial pass, or after the serial
//   pass and the divider when the request confirms a trip end, and req_stall
//   falls in that same cycle. Both timestamp differences and the hold-time
//   comparison run through shift registers (32 bits, 16 for hold_ms) one bit
//   per cycle, and the speed comes from a restoring divider that produces
//   one quotient bit per cycle. One request is processed at a time;
//   req_stall is high from acceptance until the response is registered.
//   The response register frees the engine: a new request may be accepted
//   while the previous response still waits. If the receiver stalls, a
//   finished request waits in its last step until the response register
//   is free. Reset (synchronous, active high) returns every register and
//   detector state to its reset value; there is no clearing pass.
//   The user must write registers through csr_* only while the block is idle; it is not enforced.
module modulated_beam_trip_detector
   import mbtd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Configuration write port
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   // Request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ADC_W-1:0]     req_adc_sample,
   input  logic [TIME_W-1:0]    req_time_us,
   input  logic [TIME_W-1:0]    req_time_ms,
   // Response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_laser_drive,
   output logic                 rsp_indicator_led,
   output logic                 rsp_beam_tripped,
   output logic                 rsp_trip_start_event,
   output logic                 rsp_trip_clear_event,
   output logic                 rsp_trip_end_event,
   output logic [SPEED_W-1:0]   rsp_object_speed
);

`include "assert_macros.svh"

   // Sequencer codes.
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SERIAL = 2'd1;
   localparam logic [1:0] S_DIVIDE = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   // Sequencer and response handshake.
   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Configuration registers.
   logic [ADC_W-1:0]   margin_ff, margin_in;
   logic [CNT_W-1:0]   miss_limit_ff, miss_limit_in;
   logic [HOLD_W-1:0]  hold_ms_ff, hold_ms_in;
   logic [RET_W-1:0]   return_ff, return_in;
   logic [SPEED_W-1:0] numer_ff, numer_in;

   // Detector state.
   logic               laser_ff, laser_in;
   logic [ADC_W-1:0]   prev_ff, prev_in;
   logic [CNT_W-1:0]   miss_ff, miss_in;
   logic [GOOD_W-1:0]  good_ff, good_in;
   logic [RET_W-1:0]   back_ff, back_in;
   logic               tripped_ff, tripped_in;
   logic               ended_ff, ended_in;
   logic               led_ff, led_in;
   logic [TIME_W-1:0]  start_ff, start_in;
   logic [TIME_W-1:0]  end_ff, end_in;
   logic [TIME_W-1:0]  hold_start_ff, hold_start_in;
   logic [SPEED_W-1:0] speed_ff, speed_in;

   // Flags carried from acceptance to the finishing step.
   step_flags_type flags_ff, flags_in;

   // Bit-serial datapath: operands shift out LSB first.
   logic [TIME_W-1:0]  sh_now_ms_ff, sh_now_ms_in;
   logic [TIME_W-1:0]  sh_hstart_ff, sh_hstart_in;
   logic [HOLD_W-1:0]  sh_hold_ff, sh_hold_in;
   logic [TIME_W-1:0]  sh_end_ff, sh_end_in;
   logic [TIME_W-1:0]  sh_start_ff, sh_start_in;
   logic [TIME_W-1:0]  dur_ff, dur_in;
   logic               br_ms_ff, br_ms_in;
   logic               br_cmp_ff, br_cmp_in;
   logic               br_dur_ff, br_dur_in;

   // Divider: remainder and numerator/quotient shift register.
   logic [TIME_W-1:0]  rem_ff, rem_in;
   logic [SPEED_W-1:0] quo_ff, quo_in;

   // Response payload.
   logic               o_laser_ff, o_laser_in;
   logic               o_led_ff, o_led_in;
   logic               o_tripped_ff, o_tripped_in;
   logic               o_start_ff, o_start_in;
   logic               o_clear_ff, o_clear_in;
   logic               o_end_ff, o_end_in;
   logic [SPEED_W-1:0] o_speed_ff, o_speed_in;

   // Combinational working values.
   logic              accept;
   logic              rsp_free;
   logic              laser_new;
   logic              seen;
   logic [ADC_W:0]    prev_plus;
   logic [ADC_W:0]    rdg_plus;
   logic [CNT_W-1:0]  miss_a;
   logic [GOOD_W-1:0] good_a;
   logic [GOOD_W-1:0] good_t;
   logic [RET_W-1:0]  back_a;
   logic [RET_W-1:0]  back_b;
   logic [TIME_W-1:0] start_a;
   logic [TIME_W-1:0] end_b;
   logic              ended_b;
   logic              ev_end;
   logic              trip;
   logic              bit_ms;
   logic              bit_hs;
   logic              bit_hold;
   logic              bit_end;
   logic              bit_start;
   logic              diff_ms;
   logic              diff_dur;
   logic [TIME_W:0]   trial;

   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   // Modulation check and counter updates for the request being accepted.
   always_comb begin
      laser_new = !laser_ff;
      prev_plus = {1'b0, prev_ff} + {1'b0, margin_ff};
      rdg_plus  = {1'b0, req_adc_sample} + {1'b0, margin_ff};
      // A rise beyond the margin with the laser on, a fall with it off.
      seen = laser_new ? ({1'b0, req_adc_sample} > prev_plus)
                       : ({1'b0, prev_ff} > rdg_plus);

      miss_a  = miss_ff;
      good_a  = good_ff;
      good_t  = good_ff + GOOD_W'(miss_ff != '0);
      back_a  = back_ff;
      start_a = start_ff;
      if (!seen) begin
         miss_a = (miss_ff != MISS_MAX) ? miss_ff + 1'b1 : miss_ff;
         back_a = '0;
      end else if (!tripped_ff) begin
         start_a = req_time_us;
         if (good_t > GOOD_LIMIT) begin
            miss_a = '0;
            good_a = '0;
         end else begin
            good_a = good_t;
         end
      end

      // Consecutive seen samples confirm that the beam has returned.
      back_b  = back_a;
      end_b   = end_ff;
      ended_b = ended_ff;
      ev_end  = 1'b0;
      if (seen && !ended_ff) begin
         back_b = (back_a != BACK_MAX) ? back_a + 1'b1 : back_a;
         if (back_b == RET_W'(1)) begin
            end_b = req_time_us;
         end
         if (back_b > return_ff) begin
            ended_b = 1'b1;
            ev_end  = 1'b1;
         end
      end

      trip = (miss_a > miss_limit_ff);
   end

   // Bit-serial subtractors: now_ms - hold_start, then that minus hold_ms,
   // and end stamp minus start stamp for the trip duration.
   always_comb begin
      bit_ms    = sh_now_ms_ff[0];
      bit_hs    = sh_hstart_ff[0];
      bit_hold  = sh_hold_ff[0];
      bit_end   = sh_end_ff[0];
      bit_start = sh_start_ff[0];
      diff_ms   = bit_ms ^ bit_hs ^ br_ms_ff;
      diff_dur  = bit_end ^ bit_start ^ br_dur_ff;
   end

   // Next-state logic.
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff;
      margin_in     = margin_ff;
      miss_limit_in = miss_limit_ff;
      hold_ms_in    = hold_ms_ff;
      return_in     = return_ff;
      numer_in      = numer_ff;
      laser_in      = laser_ff;
      prev_in       = prev_ff;
      miss_in       = miss_ff;
      good_in       = good_ff;
      back_in       = back_ff;
      tripped_in    = tripped_ff;
      ended_in      = ended_ff;
      led_in        = led_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      hold_start_in = hold_start_ff;
      speed_in      = speed_ff;
      flags_in      = flags_ff;
      sh_now_ms_in  = sh_now_ms_ff;
      sh_hstart_in  = sh_hstart_ff;
      sh_hold_in    = sh_hold_ff;
      sh_end_in     = sh_end_ff;
      sh_start_in   = sh_start_ff;
      dur_in        = dur_ff;
      br_ms_in      = br_ms_ff;
      br_cmp_in     = br_cmp_ff;
      br_dur_in     = br_dur_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      o_laser_in    = o_laser_ff;
      o_led_in      = o_led_ff;
      o_tripped_in  = o_tripped_ff;
      o_start_in    = o_start_ff;
      o_clear_in    = o_clear_ff;
      o_end_in      = o_end_ff;
      o_speed_in    = o_speed_ff;
      trial         = {rem_ff, quo_ff[SPEED_W-1]} - {1'b0, dur_ff};

      // Configuration writes; indexes beyond the list are ignored.
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CHANGE_MARGIN:   margin_in     = csr_wdata[ADC_W-1:0];
            CSR_MISS_LIMIT:      miss_limit_in = csr_wdata[CNT_W-1:0];
            CSR_HOLD_MS:         hold_ms_in    = csr_wdata[HOLD_W-1:0];
            CSR_RETURN_COUNT:    return_in     = csr_wdata[RET_W-1:0];
            CSR_SPEED_NUMERATOR: numer_in      = csr_wdata[SPEED_W-1:0];
            default: ;
         endcase
      end

      // The response register empties when the receiver takes it.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // Everything but the hold-time branch is settled here.
               laser_in = laser_new;
               prev_in  = req_adc_sample;
               back_in  = back_b;
               start_in = start_a;
               end_in   = end_b;
               flags_in.trip     = trip;
               flags_in.ev_start = trip && !tripped_ff;
               flags_in.ev_end   = ev_end;
               if (trip) begin
                  ended_in      = tripped_ff ? ended_b : 1'b0;
                  hold_start_in = req_time_ms;
                  miss_in       = '0;
                  good_in       = '0;
               end else begin
                  ended_in = ended_b;
                  miss_in  = miss_a;
                  good_in  = good_a;
               end
               // Load the serial operands; the hold test uses the old start.
               sh_now_ms_in = req_time_ms;
               sh_hstart_in = hold_start_ff;
               sh_hold_in   = hold_ms_ff;
               sh_end_in    = end_b;
               sh_start_in  = start_a;
               br_ms_in     = 1'b0;
               br_cmp_in    = 1'b0;
               br_dur_in    = 1'b0;
               step_in      = '0;
               state_in     = S_SERIAL;
            end
         end

         S_SERIAL: begin
            // One bit of each subtraction per cycle, LSB first.
            br_ms_in  = (!bit_ms && bit_hs) || (!(bit_ms ^ bit_hs) && br_ms_ff);
            br_cmp_in = (!diff_ms && bit_hold) || (!(diff_ms ^ bit_hold) && br_cmp_ff);
            br_dur_in = (!bit_end && bit_start) || (!(bit_end ^ bit_start) && br_dur_ff);
            dur_in       = {diff_dur, dur_ff[TIME_W-1:1]};
            sh_now_ms_in = {1'b0, sh_now_ms_ff[TIME_W-1:1]};
            sh_hstart_in = {1'b0, sh_hstart_ff[TIME_W-1:1]};
            sh_hold_in   = {1'b0, sh_hold_ff[HOLD_W-1:1]};
            sh_end_in    = {1'b0, sh_end_ff[TIME_W-1:1]};
            sh_start_in  = {1'b0, sh_start_ff[TIME_W-1:1]};
            step_in      = step_ff + 1'b1;
            if (step_ff == LAST_BIT_STEP) begin
               step_in = '0;
               if (flags_ff.ev_end) begin
                  rem_in   = '0;
                  quo_in   = numer_ff;
                  state_in = S_DIVIDE;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end

         S_DIVIDE: begin
            // Restoring division, one quotient bit per cycle. A zero duration
            // never borrows, so the quotient saturates to all ones by itself.
            if (!trial[TIME_W]) begin
               rem_in = trial[TIME_W-1:0];
               quo_in = {quo_ff[SPEED_W-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[TIME_W-2:0], quo_ff[SPEED_W-1]};
               quo_in = {quo_ff[SPEED_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_DIV_STEP) begin
               step_in  = '0;
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (rsp_free) begin
               o_tripped_in = tripped_ff;
               o_led_in     = led_ff;
               o_clear_in   = 1'b0;
               if (flags_ff.trip) begin
                  tripped_in   = 1'b1;
                  led_in       = 1'b1;
                  o_tripped_in = 1'b1;
                  o_led_in     = 1'b1;
               end else if (!br_cmp_ff) begin
                  // Hold time has run out.
                  tripped_in   = 1'b0;
                  led_in       = 1'b0;
                  o_tripped_in = 1'b0;
                  o_led_in     = 1'b0;
                  o_clear_in   = tripped_ff;
               end
               if (flags_ff.ev_end) begin
                  speed_in   = quo_ff;
                  o_speed_in = quo_ff;
               end else begin
                  o_speed_in = speed_ff;
               end
               o_laser_in   = laser_ff;
               o_start_in   = flags_ff.ev_start;
               o_end_in     = flags_ff.ev_end;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control and detector state, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         margin_ff     <= MARGIN_RST;
         miss_limit_ff <= MISS_LIMIT_RST;
         hold_ms_ff    <= HOLD_MS_RST;
         return_ff     <= RETURN_RST;
         numer_ff      <= NUMERATOR_RST;
         laser_ff      <= 1'b0;
         prev_ff       <= '0;
         miss_ff       <= '0;
         good_ff       <= '0;
         back_ff       <= '0;
         tripped_ff    <= 1'b0;
         ended_ff      <= 1'b1;
         led_ff        <= 1'b1;
         start_ff      <= '0;
         end_ff        <= '0;
         hold_start_ff <= '0;
         speed_ff      <= '0;
         flags_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         rsp_valid_ff  <= rsp_valid_in;
         margin_ff     <= margin_in;
         miss_limit_ff <= miss_limit_in;
         hold_ms_ff    <= hold_ms_in;
         return_ff     <= return_in;
         numer_ff      <= numer_in;
         laser_ff      <= laser_in;
         prev_ff       <= prev_in;
         miss_ff       <= miss_in;
         good_ff       <= good_in;
         back_ff       <= back_in;
         tripped_ff    <= tripped_in;
         ended_ff      <= ended_in;
         led_ff        <= led_in;
         start_ff      <= start_in;
         end_ff        <= end_in;
         hold_start_ff <= hold_start_in;
         speed_ff      <= speed_in;
         flags_ff      <= flags_in;
      end
   end

   // Datapath and response payload, no reset needed.
   always_ff @(posedge clock) begin
      sh_now_ms_ff <= sh_now_ms_in;
      sh_hstart_ff <= sh_hstart_in;
      sh_hold_ff   <= sh_hold_in;
      sh_end_ff    <= sh_end_in;
      sh_start_ff  <= sh_start_in;
      dur_ff       <= dur_in;
      br_ms_ff     <= br_ms_in;
      br_cmp_ff    <= br_cmp_in;
      br_dur_ff    <= br_dur_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      o_laser_ff   <= o_laser_in;
      o_led_ff     <= o_led_in;
      o_tripped_ff <= o_tripped_in;
      o_start_ff   <= o_start_in;
      o_clear_ff   <= o_clear_in;
      o_end_ff     <= o_end_in;
      o_speed_ff   <= o_speed_in;
   end

   // Response ports.
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_laser_drive      = o_laser_ff;
   assign rsp_indicator_led    = o_led_ff;
   assign rsp_beam_tripped     = o_tripped_ff;
   assign rsp_trip_start_event = o_start_ff;
   assign rsp_trip_clear_event = o_clear_ff;
   assign rsp_trip_end_event   = o_end_ff;
   assign rsp_object_speed     = o_speed_ff;

   // Checks.
   `MBTD_ASSERT(a_accept_starts_serial, clock, reset, accept |=> (state_ff == S_SERIAL), "accepted request did not start the serial pass")
   `MBTD_ASSERT(a_divide_needs_end, clock, reset, (state_ff == S_DIVIDE) |-> flags_ff.ev_end, "divider running without a trip end")
   `MBTD_ASSERT(a_start_not_clear, clock, reset, rsp_valid_ff |-> !(o_start_ff && o_clear_ff), "trip start and clear in one response")
   `MBTD_ASSERT(a_start_sets_flags, clock, reset, (rsp_valid_ff && o_start_ff) |-> (o_tripped_ff && o_led_ff), "trip start without trip flag and LED")
   `MBTD_ASSERT_ALWAYS(a_no_load_while_busy, clock, (rsp_valid_ff && rsp_stall && state_ff == S_FINISH) |=> (state_ff == S_FINISH), "finished request left while response was stalled")

endmodule

@@ verif/trip_detector_checker.sv @@
// Checker for the modulated beam trip detector: predicts every response from
// the accepted requests and register writes, and compares them in order.
// Depends on mbtd_pkg for widths, register indexes and reset values.
module trip_detector_checker
   import mbtd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [ADC_W-1:0]     req_adc_sample,
   input  logic [TIME_W-1:0]    req_time_us,
   input  logic [TIME_W-1:0]    req_time_ms,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 rsp_laser_drive,
   input  logic                 rsp_indicator_led,
   input  logic                 rsp_beam_tripped,
   input  logic                 rsp_trip_start_event,
   input  logic                 rsp_trip_clear_event,
   input  logic                 rsp_trip_end_event,
   input  logic [SPEED_W-1:0]   rsp_object_speed,
   output int                   failures,
   output int                   pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [SPEED_W-1:0] SPEED_FULL = '1;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic               laser;
      logic               led;
      logic               tripped;
      logic               ev_start;
      logic               ev_clear;
      logic               ev_end;
      logic [SPEED_W-1:0] speed;
   } beam_verdict_type;

   // Configuration as last written.
   logic [ADC_W-1:0]   margin_cfg;
   logic [CNT_W-1:0]   miss_limit_cfg;
   logic [HOLD_W-1:0]  hold_cfg;
   logic [RET_W-1:0]   return_cfg;
   logic [SPEED_W-1:0] numerator_cfg;

   // Detector state.
   logic               laser_on;
   logic [ADC_W-1:0]   last_reading;
   logic [CNT_W-1:0]   misses;
   logic [GOOD_W-1:0]  good_run;
   logic [RET_W-1:0]   back_run;
   logic               tripped;
   logic               trip_ended;
   logic               led_on;
   logic [TIME_W-1:0]  start_us;
   logic [TIME_W-1:0]  end_us;
   logic [TIME_W-1:0]  hold_from_ms;
   logic [SPEED_W-1:0] speed_held;

   beam_verdict_type expected_verdicts[$];
   int mismatches = 0;

   // Works out the response to one sample and advances the detector state.
   function automatic beam_verdict_type predict_sample(input logic [ADC_W-1:0] reading,
                                                       input logic [TIME_W-1:0] now_us,
                                                       input logic [TIME_W-1:0] now_ms);
      beam_verdict_type v;
      int delta;
      logic seen;
      logic [TIME_W-1:0] duration;
      logic [TIME_W-1:0] quotient;
      logic [TIME_W-1:0] elapsed_ms;
      v = '0;
      laser_on = ~laser_on;

      // The modulation is seen when the reading moved with the laser by more than the margin.
      delta = int'(reading) - int'(last_reading);
      if (laser_on) begin
         seen = delta > int'(margin_cfg);
      end else begin
         seen = -delta > int'(margin_cfg);
      end

      // Miss and recovery counting.
      if (!seen) begin
         if (misses != MISS_MAX) begin
            misses++;
         end
         back_run = '0;
      end else if (!tripped) begin
         start_us = now_us;
         if (misses != '0) begin
            good_run++;
         end
         if (good_run > GOOD_LIMIT) begin
            misses = '0;
            good_run = '0;
         end
      end

      // Returning beam: confirm the trip end and work out the speed.
      if (seen && !trip_ended) begin
         if (back_run != BACK_MAX) begin
            back_run++;
         end
         if (back_run == RET_W'(1)) begin
            end_us = now_us;
         end
         if (back_run > return_cfg) begin
            trip_ended = 1'b1;
            duration = end_us - start_us;
            if (duration == '0) begin
               speed_held = SPEED_FULL;
            end else begin
               quotient = TIME_W'(numerator_cfg) / duration;
               speed_held = (quotient > TIME_W'(SPEED_FULL)) ? SPEED_FULL : quotient[SPEED_W-1:0];
            end
            v.ev_end = 1'b1;
         end
      end

      // Trip declaration first, otherwise the hold time may run out.
      elapsed_ms = now_ms - hold_from_ms;
      if (misses > miss_limit_cfg) begin
         led_on = 1'b1;
         if (!tripped) begin
            trip_ended = 1'b0;
            v.ev_start = 1'b1;
         end
         tripped = 1'b1;
         hold_from_ms = now_ms;
         misses = '0;
         good_run = '0;
      end else if (elapsed_ms >= TIME_W'(hold_cfg)) begin
         led_on = 1'b0;
         if (tripped) begin
            v.ev_clear = 1'b1;
         end
         tripped = 1'b0;
      end

      last_reading = reading;
      v.laser = laser_on;
      v.led = led_on;
      v.tripped = tripped;
      v.speed = speed_held;
      return v;
   endfunction

   // Compares one response field and reports the first few differences.
   function automatic void check_field(input string field, input logic [SPEED_W-1:0] want,
                                       input logic [SPEED_W-1:0] got);
      if (want !== got) begin
         if (mismatches < REPORT_LIMIT) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
         end
         mismatches++;
      end
   endfunction

   // Follows writes, requests and responses at each rising edge.
   always @(posedge clock) begin : watch
      beam_verdict_type want;
      if (reset) begin
         margin_cfg = MARGIN_RST;
         miss_limit_cfg = MISS_LIMIT_RST;
         hold_cfg = HOLD_MS_RST;
         return_cfg = RETURN_RST;
         numerator_cfg = NUMERATOR_RST;
         laser_on = 1'b0;
         last_reading = '0;
         misses = '0;
         good_run = '0;
         back_run = '0;
         tripped = 1'b0;
         trip_ended = 1'b1;
         led_on = 1'b1;
         start_us = '0;
         end_us = '0;
         hold_from_ms = '0;
         speed_held = '0;
         expected_verdicts.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CHANGE_MARGIN:   margin_cfg = csr_wdata[ADC_W-1:0];
               CSR_MISS_LIMIT:      miss_limit_cfg = csr_wdata[CNT_W-1:0];
               CSR_HOLD_MS:         hold_cfg = csr_wdata[HOLD_W-1:0];
               CSR_RETURN_COUNT:    return_cfg = csr_wdata[RET_W-1:0];
               CSR_SPEED_NUMERATOR: numerator_cfg = csr_wdata[SPEED_W-1:0];
               default: ;
            endcase
         end

         // Responses are matched before this edge's request is added.
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               if (mismatches < REPORT_LIMIT) begin
                  $display("%0t: response with no request outstanding", $realtime);
               end
               mismatches++;
            end else begin
               want = expected_verdicts.pop_front();
               check_field("laser_drive", want.laser, rsp_laser_drive);
               check_field("indicator_led", want.led, rsp_indicator_led);
               check_field("beam_tripped", want.tripped, rsp_beam_tripped);
               check_field("trip_start_event", want.ev_start, rsp_trip_start_event);
               check_field("trip_clear_event", want.ev_clear, rsp_trip_clear_event);
               check_field("trip_end_event", want.ev_end, rsp_trip_end_event);
               check_field("object_speed", want.speed, rsp_object_speed);
            end
         end

         if (req_valid && !req_stall) begin
            expected_verdicts.push_back(predict_sample(req_adc_sample, req_time_us,
                                                       req_time_ms));
         end
      end
      pending_results <= expected_verdicts.size();
      failures <= mismatches;
   end

endmodule

@@ verif/testbench.sv @@
// Top of the trip detector testbench: clock, reset, register writes and sample
// requests with random idling. Depends on mbtd_pkg, the detector RTL and
// trip_detector_checker, which predicts and compares the responses.
module testbench
   import mbtd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 100;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 100;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = CSR_SPEED_NUMERATOR + 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_INDEX   = '1;

   typedef enum {RUN_BEAM, RUN_BLOCKED, RUN_NOISE} run_kind_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [ADC_W-1:0]     req_adc_sample = '0;
   logic [TIME_W-1:0]    req_time_us = '0;
   logic [TIME_W-1:0]    req_time_ms = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_laser_drive;
   logic                 rsp_indicator_led;
   logic                 rsp_beam_tripped;
   logic                 rsp_trip_start_event;
   logic                 rsp_trip_clear_event;
   logic                 rsp_trip_end_event;
   logic [SPEED_W-1:0]   rsp_object_speed;

   int failures;
   int pending_results;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int samples_sent = 0;
   int cur_margin = 10;
   int cur_limit = 20;

   modulated_beam_trip_detector dut (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_adc_sample       (req_adc_sample),
      .req_time_us          (req_time_us),
      .req_time_ms          (req_time_ms),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_laser_drive      (rsp_laser_drive),
      .rsp_indicator_led    (rsp_indicator_led),
      .rsp_beam_tripped     (rsp_beam_tripped),
      .rsp_trip_start_event (rsp_trip_start_event),
      .rsp_trip_clear_event (rsp_trip_clear_event),
      .rsp_trip_end_event   (rsp_trip_end_event),
      .rsp_object_speed     (rsp_object_speed)
   );

   trip_detector_checker trip_checker (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_adc_sample       (req_adc_sample),
      .req_time_us          (req_time_us),
      .req_time_ms          (req_time_ms),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_laser_drive      (rsp_laser_drive),
      .rsp_indicator_led    (rsp_indicator_led),
      .rsp_beam_tripped     (rsp_beam_tripped),
      .rsp_trip_start_event (rsp_trip_start_event),
      .rsp_trip_clear_event (rsp_trip_clear_event),
      .rsp_trip_end_event   (rsp_trip_end_event),
      .rsp_object_speed     (rsp_object_speed),
      .failures             (failures),
      .pending_results      (pending_results)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The receiver stalls at random, independently of the response valid.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Guard against a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Idling pattern: sender light and receiver heavy, then reversed, then none.
   task automatic set_idling(input int phase);
      if (phase < 3) begin
         send_idle_pct = 10;
         recv_idle_pct = 65;
      end else if (phase < 6) begin
         send_idle_pct = 65;
         recv_idle_pct = 10;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   // Presents one request, after a random gap, and holds it until accepted.
   task automatic send_sample(input logic [ADC_W-1:0] adc, input logic [TIME_W-1:0] now_us,
                              input logic [TIME_W-1:0] now_ms);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_adc_sample <= adc;
      req_time_us <= now_us;
      req_time_ms <= now_ms;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      samples_sent++;
   endtask

   // Stops sending and waits until every response has been checked.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Writes all five registers with junk in any unused upper bits, plus one
   // write to an index beyond the register list, which must be ignored.
   task automatic configure(input logic [ADC_W-1:0] margin, input logic [CNT_W-1:0] limit,
                            input logic [HOLD_W-1:0] hold, input logic [RET_W-1:0] ret,
                            input logic [SPEED_W-1:0] numerator);
      logic [CSR_DAT_W-1:0] junk;
      junk = CSR_DAT_W'($urandom);
      write_reg(CSR_CHANGE_MARGIN, {junk[CSR_DAT_W-1:ADC_W], margin});
      write_reg(CSR_MISS_LIMIT, {junk[CSR_DAT_W-1:CNT_W], limit});
      write_reg(CSR_HOLD_MS, {junk[CSR_DAT_W-1:HOLD_W], hold});
      write_reg(CSR_RETURN_COUNT, {junk[CSR_DAT_W-1:RET_W], ret});
      write_reg(CSR_SPEED_NUMERATOR, numerator);
      write_reg(CSR_IDX_W'($urandom_range(int'(CSR_LAST_INDEX), int'(CSR_FIRST_UNUSED))),
                CSR_DAT_W'($urandom));
      csr_wr_en <= 1'b0;
      cur_margin = int'(margin);
      cur_limit = int'(limit);
   endtask

   // Random traffic built from runs: a modulated beam that follows the laser,
   // a blocked beam with small noise, and short bursts of arbitrary readings.
   task automatic run_random(input int count);
      run_kind_type kind;
      int run_left;
      int pick;
      int base;
      int amp;
      int reading;
      logic [TIME_W-1:0] now_us;
      logic [TIME_W-1:0] now_ms;
      kind = RUN_NOISE;
      run_left = 0;
      base = 0;
      amp = 0;
      now_us = $urandom;
      now_ms = $urandom;
      if ($urandom_range(0, 1) == 1) begin
         now_us = '1 - TIME_W'($urandom_range(0, 50000));
         now_ms = '1 - TIME_W'($urandom_range(0, 300));
      end
      for (int n = 0; n < count; n++) begin
         if (run_left == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               kind = RUN_BEAM;
               run_left = $urandom_range(1, 40);
            end else if (pick < 90) begin
               kind = RUN_BLOCKED;
               run_left = $urandom_range(1, (cur_limit + 4 < 60) ? cur_limit + 4 : 60);
            end else begin
               kind = RUN_NOISE;
               run_left = $urandom_range(1, 8);
            end
            amp = cur_margin + 1 + $urandom_range(0, 40);
            if (amp > 1023) begin
               amp = 1023;
            end
            base = $urandom_range(0, 1023 - amp);
         end
         run_left--;

         case (kind)
            RUN_BEAM:    reading = (samples_sent % 2 == 0) ? base + amp : base;
            RUN_BLOCKED: reading = base + $urandom_range(0, cur_margin / 2);
            default:     reading = $urandom_range(0, 1023);
         endcase

         // Timestamps mostly advance steadily, with repeats, jumps and wild values.
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            now_ms = now_ms + TIME_W'($urandom_range(0, 1));
         end else if (pick < 8) begin
            now_us = $urandom;
            now_ms = $urandom;
         end else if (pick < 13) begin
            now_us = now_us + TIME_W'($urandom_range(0, 1 << 20));
            now_ms = now_ms + TIME_W'($urandom_range(0, 70000));
         end else begin
            now_us = now_us + TIME_W'($urandom_range(100, 2000));
            now_ms = now_ms + TIME_W'($urandom_range(0, 2));
         end
         send_sample(ADC_W'(reading), now_us, now_ms);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      set_idling(0);

      // Reset configuration: full-scale readings, timestamp extremes and the
      // margin boundary, where a step equal to the margin is a miss.
      send_sample(10'h3FF, 32'h0000_0000, 32'h0000_0000);
      send_sample(10'h000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_sample(10'h00A, 32'h5555_5555, 32'hAAAA_AAAA);
      send_sample(10'h000, 32'hAAAA_AAAA, 32'h5555_5555);
      send_sample(10'h00B, 32'd1000, 32'd10);
      send_sample(10'h000, 32'd2000, 32'd11);
      send_sample(10'h3FF, 32'd3000, 32'd12);
      send_sample(10'h3FF, 32'd4000, 32'd13);
      send_sample(10'h000, 32'd5000, 32'd14);
      send_sample(10'h3FF, 32'd6000, 32'd15);
      wait_for_results();

      // Immediate trips with no hold: a normal trip end, one with zero
      // duration and one whose duration spans the microsecond wrap.
      configure(10'd10, 16'd0, 16'd0, 4'd0, NUMERATOR_RST);
      send_sample(10'h3FF, 32'd7000, 32'd16);
      send_sample(10'h000, 32'd7500, 32'd16);
      send_sample(10'd500, 32'd8000, 32'd17);
      send_sample(10'd500, 32'd8000, 32'd17);
      send_sample(10'd900, 32'd8000, 32'd18);
      send_sample(10'd100, 32'hFFFF_FFF0, 32'hFFFF_FFFE);
      send_sample(10'd100, 32'hFFFF_FFF8, 32'hFFFF_FFFF);
      send_sample(10'd000, 32'h0000_0010, 32'h0000_0000);

      // Random phases, each under its own configuration.
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_results();
         set_idling(phase);
         case (phase)
            0: configure(MARGIN_RST, MISS_LIMIT_RST, HOLD_MS_RST, RETURN_RST, NUMERATOR_RST);
            1: configure('0, '0, '0, '0, SPEED_W'(1));
            2: configure('1, 16'd3, '1, 4'd1, '1);
            3: configure(10'd50, '1, 16'd5, 4'd15, '1);
            4: configure(ADC_W'($urandom_range(1, 60)), 16'd5, HOLD_W'($urandom_range(0, 20)),
                         4'd15, SPEED_W'($urandom));
            7: configure(ADC_W'($urandom_range(0, 120)), CNT_W'($urandom_range(0, 12)),
                         HOLD_W'($urandom_range(0, 30)), RET_W'($urandom_range(0, 15)), '0);
            default: configure(ADC_W'($urandom_range(0, 120)), CNT_W'($urandom_range(0, 12)),
                               HOLD_W'($urandom_range(0, 30)), RET_W'($urandom_range(0, 15)),
                               SPEED_W'($urandom));
         endcase
         run_random(PHASE_ITEMS);
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
